/* hdl/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the nearest-point symbol slicer
// Field widths of the ports, operation codes, back-end states and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package nps_pkg;

	localparam int FIELD_W = 16;  // coordinate fields on the ports
	localparam int IDX_W   = 4;   // entry_index and best_index
	localparam int SYM_W   = 8;   // symbol byte
	localparam int DIST_W  = 33;  // best_distance port
	localparam int CFG_W   = 5;   // points_in_use register
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} back_state_t;

	// register index is paddr[2]
	localparam logic REG_POINTS_IN_USE = 1'b0;

	localparam logic [CFG_W-1:0] POINTS_RESET = CFG_W'(1);

endpackage

/* hdl/nps_front.sv */
// ----------------------------------------------------------------------------
// nps_front: input stage
// Accepts transactions, drops writes beyond the table, narrows coordinates
// and resolves the search range into a command for the queue.
// ----------------------------------------------------------------------------
module nps_front import nps_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int COORD_BITS  = 16,
	localparam int AW     = $clog2(TABLE_DEPTH),
	localparam int CMD_W  = 1 + 2 * AW + 2 * COORD_BITS + SYM_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic        [IDX_W-1:0]   entry_index,
	input  logic signed [FIELD_W-1:0] entry_i,
	input  logic signed [FIELD_W-1:0] entry_q,
	input  logic        [SYM_W-1:0]   entry_symbol,
	input  logic signed [FIELD_W-1:0] sample_i,
	input  logic signed [FIELD_W-1:0] sample_q,
	input  logic        [CFG_W-1:0]   points_in_use,
	output logic                      cmd_valid,
	input  logic                      cmd_stall,
	output logic        [CMD_W-1:0]   cmd
);

	localparam int RAW_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

	logic                  v_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic                  accept;
	logic                  keep;
	op_t                   op_in;
	logic [FIELD_W-1:0]    sel_i;
	logic [FIELD_W-1:0]    sel_q;
	logic [RAW_W-1:0]      raw_i;
	logic [RAW_W-1:0]      raw_q;
	logic [AW-1:0]         last_idx;

	assign op_in    = op_t'(func);
	assign in_stall = v_s1 && cmd_stall;
	assign accept   = in_valid && !in_stall;

	// drop writes to slots past the table
	assign keep = (op_in == OP_DECODE) ||
		({{(32 - IDX_W){1'b0}}, entry_index} < 32'(TABLE_DEPTH));

	// the field is a raw bit pattern; keep its low COORD_BITS bits
	assign sel_i = (op_in == OP_WRITE) ? entry_i : sample_i;
	assign sel_q = (op_in == OP_WRITE) ? entry_q : sample_q;
	assign raw_i = RAW_W'(sel_i);
	assign raw_q = RAW_W'(sel_q);

	// clamp the search range to 1..TABLE_DEPTH
	always_comb begin
		if (points_in_use == '0) begin
			last_idx = '0;
		end else if ({{(32 - CFG_W){1'b0}}, points_in_use} > 32'(TABLE_DEPTH)) begin
			last_idx = AW'(TABLE_DEPTH - 1);
		end else begin
			last_idx = AW'(points_in_use - CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || !cmd_stall) begin
			v_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= {func, AW'(entry_index), last_idx, raw_i[COORD_BITS-1:0],
				raw_q[COORD_BITS-1:0], entry_symbol};
		end
	end

	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

endmodule

/* hdl/nps_fifo.sv */
// ----------------------------------------------------------------------------
// nps_fifo: two-entry command queue
// Decouples the input stage from the table scan.
// ----------------------------------------------------------------------------
module nps_fifo import nps_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_stall,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_stall,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_stall = (count_q == 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/nps_back.sv */
// ----------------------------------------------------------------------------
// nps_back: table and nearest-point search
// Executes queued commands: writes a table slot, or scans the slots one a
// cycle through a distance pipeline and holds the result in an output
// register.
// ----------------------------------------------------------------------------
module nps_back import nps_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int COORD_BITS  = 16,
	localparam int AW     = $clog2(TABLE_DEPTH),
	localparam int CMD_W  = 1 + 2 * AW + 2 * COORD_BITS + SYM_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [CMD_W-1:0]   cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SYM_W-1:0]   symbol,
	output logic [IDX_W-1:0]   best_index,
	output logic [DIST_W-1:0]  best_distance
);

	localparam int C        = COORD_BITS;
	localparam int MEM_W    = 2 * C + SYM_W;
	localparam int SQ_W     = 2 * C;
	localparam int D_W      = 2 * C + 1;
	localparam int SYM_LSB  = 0;
	localparam int CQ_LSB   = SYM_W;
	localparam int CI_LSB   = CQ_LSB + C;
	localparam int LAST_LSB = CI_LSB + C;
	localparam int ADDR_LSB = LAST_LSB + AW;
	localparam int OP_BIT   = ADDR_LSB + AW;

	// command fields
	op_t              cmd_op;
	logic [AW-1:0]    cmd_addr;
	logic [AW-1:0]    cmd_last;
	logic [C-1:0]     cmd_ci;
	logic [C-1:0]     cmd_cq;
	logic [SYM_W-1:0] cmd_sym;

	assign cmd_op   = op_t'(cmd[OP_BIT]);
	assign cmd_addr = cmd[ADDR_LSB +: AW];
	assign cmd_last = cmd[LAST_LSB +: AW];
	assign cmd_ci   = cmd[CI_LSB +: C];
	assign cmd_cq   = cmd[CQ_LSB +: C];
	assign cmd_sym  = cmd[SYM_LSB +: SYM_W];

	back_state_t state_q;
	back_state_t state_nxt;

	logic mem_we;
	logic start;
	logic rd_issue;
	logic out_load;

	logic [MEM_W-1:0] table_mem [TABLE_DEPTH];

	logic [C-1:0]  samp_i_q;
	logic [C-1:0]  samp_q_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] k_q;

	// stage 1: table read
	logic             v_s1, first_s1, last_s1;
	logic [AW-1:0]    idx_s1;
	logic [MEM_W-1:0] rd_s1;
	// stage 2: distance magnitudes
	logic             v_s2, first_s2, last_s2;
	logic [AW-1:0]    idx_s2;
	logic [SYM_W-1:0] sym_s2;
	logic [C-1:0]     mag_i_s2, mag_q_s2;
	// stage 3: squares
	logic             v_s3, first_s3, last_s3;
	logic [AW-1:0]    idx_s3;
	logic [SYM_W-1:0] sym_s3;
	logic [SQ_W-1:0]  sq_i_s3, sq_q_s3;

	logic [D_W-1:0]   best_dist_q;
	logic [AW-1:0]    best_idx_q;
	logic [SYM_W-1:0] best_sym_q;

	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [DIST_W-1:0] out_dist_q;

	logic [C-1:0] rd_i, rd_q;
	logic [C:0]   diff_i, diff_q;
	logic [C:0]   abs_i, abs_q;
	logic [D_W-1:0] dist_sum;
	logic           better;

	// ---------------- control ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd_op == OP_DECODE) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (k_q == last_q) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (v_s3 && last_s3) begin
					state_nxt = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we   = 1'b0;
		start    = 1'b0;
		rd_issue = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mem_we = cmd_valid && (cmd_op == OP_WRITE);
				start  = cmd_valid && (cmd_op == OP_DECODE);
			end
			ST_SCAN: begin
				rd_issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_RESULT: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	assign cmd_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				k_q <= '0;
			end else if (rd_issue) begin
				k_q <= k_q + AW'(1);
			end
			v_s1 <= rd_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			samp_i_q <= cmd_ci;
			samp_q_q <= cmd_cq;
			last_q   <= cmd_last;
		end
	end

	// ---------------- point table ----------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[cmd_addr] <= {cmd_ci, cmd_cq, cmd_sym};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_s1 <= table_mem[k_q];
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		last_s1  <= (k_q == last_q);
		idx_s1   <= k_q;
	end

	// ---------------- distance pipeline ----------------
	assign rd_i   = rd_s1[CI_LSB - SYM_W + SYM_W +: C];
	assign rd_q   = rd_s1[SYM_W +: C];
	assign diff_i = {rd_i[C-1], rd_i} - {samp_i_q[C-1], samp_i_q};
	assign diff_q = {rd_q[C-1], rd_q} - {samp_q_q[C-1], samp_q_q};
	assign abs_i  = diff_i[C] ? ((C+1)'(0) - diff_i) : diff_i;
	assign abs_q  = diff_q[C] ? ((C+1)'(0) - diff_q) : diff_q;

	always_ff @(posedge clk) begin
		mag_i_s2 <= abs_i[C-1:0];
		mag_q_s2 <= abs_q[C-1:0];
		sym_s2   <= rd_s1[SYM_W-1:0];
		idx_s2   <= idx_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
	end

	always_ff @(posedge clk) begin
		sq_i_s3  <= mag_i_s2 * mag_i_s2;
		sq_q_s3  <= mag_q_s2 * mag_q_s2;
		sym_s3   <= sym_s2;
		idx_s3   <= idx_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
	end

	// strict compare keeps the lower slot on a tie
	assign dist_sum = D_W'(sq_i_s3) + D_W'(sq_q_s3);
	assign better   = v_s3 && (first_s3 || (dist_sum < best_dist_q));

	always_ff @(posedge clk) begin
		if (better) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s3;
			best_sym_q  <= sym_s3;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sym_q  <= best_sym_q;
			out_idx_q  <= IDX_W'(best_idx_q);
			out_dist_q <= DIST_W'(best_dist_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign symbol        = out_sym_q;
	assign best_index    = out_idx_q;
	assign best_distance = out_dist_q;

	// ---------------- assertions ----------------
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (k_q <= last_q))
		else $error("scan index ran past the last slot");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("distance pipeline busy while idle");

	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && last_s3) |-> (state_q == ST_DRAIN))
		else $error("last slot left the pipeline outside drain");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not presented after load");

endmodule

/* hdl/nearest_point_symbol_slicer.sv */
// ----------------------------------------------------------------------------
// nearest_point_symbol_slicer: minimum-distance constellation slicer
// Hard-decision symbol decoder over a loadable table of Q1.15 points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per item.
//   func = write loads slot entry_index with entry_i, entry_q and
//   entry_symbol; writes to slots past the table are dropped. func = decode
//   searches slots 0..N-1 (N as below) for the point nearest to
//   (sample_i, sample_q) and returns its symbol, slot and squared distance
//   on the output channel (out_valid/out_stall). Equal distances keep the
//   lower slot. Every slot searched must have been written since reset.
//   The back end takes a write while idle; a decode holds it through the
//   scan of slots 0..N-1, the pipeline drain and the result load, N being
//   points_in_use clamped to 1..TABLE_DEPTH; the single read port of the
//   point table, scanned one slot a cycle, sets this.
//   A two-entry queue and the input register keep taking transactions while
//   a scan runs; in_stall rises only when both are full. A stalled result
//   holds in the output register while the next scan proceeds.
//   Reset clears all control state and sets points_in_use to 1; the table
//   contents are undefined until written. Write points_in_use (APB, offset
//   0) only while the block is idle.
// ----------------------------------------------------------------------------
module nearest_point_symbol_slicer import nps_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int COORD_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic        [APB_AW-1:0]  paddr,
	input  logic        [APB_DW-1:0]  pwdata,
	output logic        [APB_DW-1:0]  prdata,
	output logic                      pready,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic        [IDX_W-1:0]   entry_index,
	input  logic signed [FIELD_W-1:0] entry_i,
	input  logic signed [FIELD_W-1:0] entry_q,
	input  logic        [SYM_W-1:0]   entry_symbol,
	input  logic signed [FIELD_W-1:0] sample_i,
	input  logic signed [FIELD_W-1:0] sample_q,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic        [SYM_W-1:0]   symbol,
	output logic        [IDX_W-1:0]   best_index,
	output logic        [DIST_W-1:0]  best_distance
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CMD_W = 1 + 2 * AW + 2 * COORD_BITS + SYM_W;

	logic [CFG_W-1:0] points_q;
	logic             cfg_wr;
	logic             reg_sel;

	logic             fq_valid;
	logic             fq_stall;
	logic [CMD_W-1:0] fq_cmd;
	logic             qb_valid;
	logic             qb_stall;
	logic [CMD_W-1:0] qb_cmd;

	// APB: zero-wait, register index taken from paddr[2]
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready &&
		(reg_sel == REG_POINTS_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= POINTS_RESET;
		end else if (cfg_wr) begin
			points_q <= pwdata[CFG_W-1:0];
		end
	end

	// return the register; unmapped offsets read zero
	assign prdata = (reg_sel == REG_POINTS_IN_USE) ? APB_DW'(points_q) : '0;

	// front end: accept, classify, drop out-of-range writes
	nps_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COORD_BITS  (COORD_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.entry_index   (entry_index),
		.entry_i       (entry_i),
		.entry_q       (entry_q),
		.entry_symbol  (entry_symbol),
		.sample_i      (sample_i),
		.sample_q      (sample_q),
		.points_in_use (points_q),
		.cmd_valid     (fq_valid),
		.cmd_stall     (fq_stall),
		.cmd           (fq_cmd)
	);

	// queue: lets the front keep accepting during a scan
	nps_fifo #(
		.WIDTH (CMD_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_stall (fq_stall),
		.push_data  (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_stall  (qb_stall),
		.pop_data   (qb_cmd)
	);

	// back end: table writes, slot scan, result register
	nps_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (qb_valid),
		.cmd_stall     (qb_stall),
		.cmd           (qb_cmd),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.symbol        (symbol),
		.best_index    (best_index),
		.best_distance (best_distance)
	);

endmodule

/* bench/nearest_point_symbol_slicer_tb.sv */
// ----------------------------------------------------------------------------
// nearest_point_symbol_slicer_tb: self-checking bench of the constellation slicer
// Loads the point table and decodes samples over several points_in_use
// settings, including out-of-range ones. Every accepted transaction is fed
// to a local nearest-point predictor, and each result is compared field by
// field with the oldest pending decision. Both channels idle at random.
// ----------------------------------------------------------------------------
module nearest_point_symbol_slicer_tb;
	import nps_pkg::*;

	localparam int TABLE_SLOTS    = 16;
	localparam int SETTLE_CYCLES  = 40;    // settling time after the last result
	localparam int HOLDOFF_CYCLES = 300;   // long receiver stall that fills the block
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 220;
	localparam logic [APB_AW-1:0] POINTS_ADDR = {REG_POINTS_IN_USE, 2'b00};

	typedef struct {
		op_t                       func;
		logic [IDX_W-1:0]          slot;
		logic signed [FIELD_W-1:0] pt_i;
		logic signed [FIELD_W-1:0] pt_q;
		logic [SYM_W-1:0]          sym;
		logic signed [FIELD_W-1:0] smp_i;
		logic signed [FIELD_W-1:0] smp_q;
	} slicer_txn_t;

	typedef struct {
		logic [SYM_W-1:0]  symbol;
		logic [IDX_W-1:0]  index;
		logic [DIST_W-1:0] distance;
	} decision_t;

	// clock, reset and DUT inputs start at known values
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = OP_WRITE;
	logic [IDX_W-1:0] entry_index = '0;
	logic signed [FIELD_W-1:0] entry_i = '0;
	logic signed [FIELD_W-1:0] entry_q = '0;
	logic [SYM_W-1:0] entry_symbol = '0;
	logic signed [FIELD_W-1:0] sample_i = '0;
	logic signed [FIELD_W-1:0] sample_q = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SYM_W-1:0] symbol;
	logic [IDX_W-1:0] best_index;
	logic [DIST_W-1:0] best_distance;

	// transactions waiting to be offered, and decisions waiting for a result
	slicer_txn_t pending_txns[$];
	decision_t   pending_decisions[$];
	slicer_txn_t offered;
	decision_t   oldest;

	// predictor copy of the table and the register
	logic signed [FIELD_W-1:0] table_i[TABLE_SLOTS];
	logic signed [FIELD_W-1:0] table_q[TABLE_SLOTS];
	logic [SYM_W-1:0]          table_sym[TABLE_SLOTS];
	logic [CFG_W-1:0]          points_reg = POINTS_RESET;

	// coordinates as the stimulus generator last wrote them
	int gen_i[TABLE_SLOTS];
	int gen_q[TABLE_SLOTS];

	int  errors = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	int  holdoff_asked = 0;
	int  holdoff_served = 0;
	int  quiet_cycles = 0;
	bit  calm = 1'b0;

	nearest_point_symbol_slicer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.entry_index  (entry_index),
		.entry_i      (entry_i),
		.entry_q      (entry_q),
		.entry_symbol (entry_symbol),
		.sample_i     (sample_i),
		.sample_q     (sample_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol       (symbol),
		.best_index   (best_index),
		.best_distance(best_distance)
	);

	always #6 clk = ~clk;

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// zero searches slot 0 only, anything past the table searches all of it
	function automatic int live_points(input logic [CFG_W-1:0] setting);
		if (setting == 0)
			return 1;
		if (setting > TABLE_SLOTS)
			return TABLE_SLOTS;
		return int'(setting);
	endfunction

	// exact squared distance to every live point, lowest slot wins a tie
	function automatic decision_t slice_sample(input logic signed [FIELD_W-1:0] si,
			input logic signed [FIELD_W-1:0] sq);
		longint di;
		longint dq;
		longint dist_sum;
		longint best_dist;
		int best_slot;
		decision_t r;
		best_slot = 0;
		best_dist = -1;
		for (int k = 0; k < live_points(points_reg); k++) begin
			di = longint'(si) - longint'(table_i[k]);
			dq = longint'(sq) - longint'(table_q[k]);
			dist_sum = di * di + dq * dq;
			if (best_dist < 0 || dist_sum < best_dist) begin
				best_dist = dist_sum;
				best_slot = k;
			end
		end
		r.symbol = table_sym[best_slot];
		r.index = IDX_W'(best_slot);
		r.distance = DIST_W'(best_dist);
		return r;
	endfunction

	// apply one accepted transaction to the predictor
	task automatic absorb_txn(input slicer_txn_t t);
		if (t.func == OP_WRITE) begin
			table_i[t.slot] = t.pt_i;
			table_q[t.slot] = t.pt_q;
			table_sym[t.slot] = t.sym;
		end else begin
			pending_decisions.push_back(slice_sample(t.smp_i, t.smp_q));
		end
	endtask

	// every field not used by the operation still gets random bits
	task automatic queue_write(input int slot, input int ci, input int cq,
			input logic [SYM_W-1:0] sym);
		slicer_txn_t t;
		t.func = OP_WRITE;
		t.slot = IDX_W'(slot);
		t.pt_i = FIELD_W'(ci);
		t.pt_q = FIELD_W'(cq);
		t.sym = sym;
		t.smp_i = FIELD_W'($urandom);
		t.smp_q = FIELD_W'($urandom);
		gen_i[slot] = ci;
		gen_q[slot] = cq;
		pending_txns.push_back(t);
	endtask

	task automatic queue_decode(input int ci, input int cq);
		slicer_txn_t t;
		t.func = OP_DECODE;
		t.slot = IDX_W'($urandom);
		t.pt_i = FIELD_W'($urandom);
		t.pt_q = FIELD_W'($urandom);
		t.sym = SYM_W'($urandom);
		t.smp_i = FIELD_W'(ci);
		t.smp_q = FIELD_W'(cq);
		pending_txns.push_back(t);
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 9))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// mostly decodes aimed near live points, with table rewrites mixed in
	task automatic queue_random(input int count, input int n_live);
		int slot;
		int other;
		int ci;
		int cq;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				slot = $urandom_range(0, TABLE_SLOTS - 1);
				if ($urandom_range(0, 3) == 0) begin
					// duplicate another point so that ties come up
					other = $urandom_range(0, TABLE_SLOTS - 1);
					queue_write(slot, gen_i[other], gen_q[other], SYM_W'($urandom));
				end else begin
					queue_write(slot, rand_coord(), rand_coord(), SYM_W'($urandom));
				end
			end else begin
				slot = $urandom_range(0, n_live - 1);
				case ($urandom_range(0, 3))
					0: begin
						ci = gen_i[slot];
						cq = gen_q[slot];
					end
					1: begin
						ci = rand_coord();
						cq = rand_coord();
					end
					default: begin
						ci = gen_i[slot] + int'($urandom_range(0, 512)) - 256;
						cq = gen_q[slot] + int'($urandom_range(0, 512)) - 256;
					end
				endcase
				ci = (ci > 32767) ? 32767 : (ci < -32768) ? -32768 : ci;
				cq = (cq > 32767) ? 32767 : (cq < -32768) ? -32768 : cq;
				queue_decode(ci, cq);
			end
		end
	endtask

	// write points_in_use, then read it back
	task automatic program_points(input logic [CFG_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= POINTS_ADDR;
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		points_reg = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== value)
			report($sformatf("points_in_use reads %0d, wrote %0d",
				prdata[CFG_W-1:0], value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until every transaction is in and every result is out, then let
	// a trailing write finish inside the block
	task automatic settle();
		do @(negedge clk);
		while (pending_txns.size() != 0 || in_valid || pending_decisions.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Driver: hold a stalled transaction, otherwise idle in bursts or offer
	// the next one. in_valid gets at most one assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				absorb_txn(offered);
			if (!(in_valid && in_stall)) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					// start an idle burst whose length send_gap draws at random
					send_gap <= $urandom_range(0, 15);
					in_valid <= 1'b0;
				end else if (pending_txns.size() != 0) begin
					offered <= pending_txns[0];
					func <= pending_txns[0].func;
					entry_index <= pending_txns[0].slot;
					entry_i <= pending_txns[0].pt_i;
					entry_q <= pending_txns[0].pt_q;
					entry_symbol <= pending_txns[0].sym;
					sample_i <= pending_txns[0].smp_i;
					sample_q <= pending_txns[0].smp_q;
					void'(pending_txns.pop_front());
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result against the oldest decision, and drive
	// out_stall with random bursts or the long hold-off when one is asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			holdoff_served <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_decisions.size() == 0) begin
					report($sformatf("result (symbol %0h, slot %0d) with no decode pending",
						symbol, best_index));
				end else begin
					oldest = pending_decisions.pop_front();
					if (symbol !== oldest.symbol)
						report($sformatf("symbol %0h, predicted %0h", symbol, oldest.symbol));
					if (best_index !== oldest.index)
						report($sformatf("best_index %0d, predicted %0d",
							best_index, oldest.index));
					if (best_distance !== oldest.distance)
						report($sformatf("best_distance %0d, predicted %0d",
							best_distance, oldest.distance));
				end
			end
			if (holdoff_served != holdoff_asked) begin
				holdoff_served <= holdoff_asked;
				stall_left <= HOLDOFF_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: any handshake on either channel or the register port
	// restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [CFG_W-1:0] phase_points[PHASES];
		int grid[4];
		grid = '{-24576, -8192, 8192, 24576};
		// full table, an empty count, the largest count (past the table), the smallest
		// count, a few in between, a random one, then the full table again
		phase_points = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd2, 5'd9, CFG_W'($urandom_range(0, 31)),
			5'd16};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Load every slot first, so that no search ever touches an unwritten
		// entry. The corners, the origin twice for a tie, and ten points of a 4x4 grid.
		queue_write(0, -32768, -32768, 8'h00);
		queue_write(1, 32767, 32767, 8'hFF);
		queue_write(2, -32768, 32767, 8'hA5);
		queue_write(3, 32767, -32768, 8'h5A);
		queue_write(4, 0, 0, 8'h3C);
		queue_write(5, 0, 0, 8'hC3);
		for (int k = 6; k < TABLE_SLOTS; k++)
			queue_write(k, grid[k % 4], grid[(k / 4) % 4], SYM_W'(8'h10 + k));
		// one point in use after reset: the largest and the zero distance
		queue_decode(32767, 32767);
		queue_decode(-32768, -32768);
		settle();

		program_points(5'd16);
		queue_decode(0, 0);
		queue_decode(-1, 0);
		queue_decode(32767, 32767);
		queue_decode(32767, -32768);
		queue_decode(100, -100);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			program_points(phase_points[p]);
			@(negedge clk);
			// idle nowhere in the middle phase and in the last one
			calm = (p == 3 || p == PHASES - 1);
			// stall the output long enough on the first phase to back up the input
			if (p == 0)
				holdoff_asked++;
			queue_random(PHASE_ITEMS, live_points(phase_points[p]));
			settle();
		end

		if (errors == 0 && pending_decisions.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
